// ===== hdl/obpt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the order best-price tracker: payload structs, codes and the
// control and status structs between the controller and the datapath.
// No dependencies.
package obpt_pkg;

   // Default depth of the order table.
   localparam int OBPT_ENTRIES = 64;

   localparam int KEY_W   = 64;
   localparam int PRICE_W = 37;

   // Empty best value in lowest mode; the empty best in highest mode is zero.
   localparam logic [PRICE_W-1:0] EMPTY_LOW_PRICE = 37'd99999990000;

   // Request command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_FULL = 2'd2,
      STAT_MISS = 2'd3
   } obpt_status_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_RESCAN = 2'd2
   } obpt_op_type;

   typedef enum logic [2:0] {
      FSM_CLEAR   = 3'd0,
      FSM_IDLE    = 3'd1,
      FSM_SCAN    = 3'd2,
      FSM_DRAIN   = 3'd3,
      FSM_COMMIT  = 3'd4,
      FSM_RESPOND = 3'd5
   } obpt_state_type;

   typedef struct packed {
      logic               cmd;
      logic [KEY_W-1:0]   order_key;
      logic [PRICE_W-1:0] order_price;
      logic               check_duplicate;
   } obpt_req_type;

   typedef struct packed {
      obpt_status_type    status;
      logic [PRICE_W-1:0] removed_price;
      logic               best_valid;
      logic [PRICE_W-1:0] best_price;
      logic [KEY_W-1:0]   best_key;
   } obpt_rsp_type;

   // One table entry as held in the memory.
   typedef struct packed {
      logic               used;
      logic [PRICE_W-1:0] price;
      logic [KEY_W-1:0]   key;
   } obpt_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_req;
      logic take_rescan;
      logic scan_step;
      logic clear_step;
      logic commit;
      logic commit_clear;
      logic load_rsp;
   } obpt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_last;
      logic rsp_free;
      logic op_is_rescan;
   } obpt_stat_type;

   // True when the candidate price beats the current best under the mode.
   function automatic logic obpt_better(input logic lowest,
                                        input logic [PRICE_W-1:0] cand,
                                        input logic [PRICE_W-1:0] cur);
      obpt_better = lowest ? (cand < cur) : (cand > cur);
   endfunction

   // Best value of an empty table under the mode.
   function automatic logic [PRICE_W-1:0] obpt_empty(input logic lowest);
      obpt_empty = lowest ? EMPTY_LOW_PRICE : '0;
   endfunction

endpackage

// ===== hdl/obpt_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module obpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/obpt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the order best-price tracker.
// Depends on obpt_pkg.
module obpt_ctrl
   import obpt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          csr_write_enable,
   input  obpt_stat_type stat,
   output obpt_cmd_type  cmd
);

   obpt_state_type state_ff, state_in;

   // A request is taken only in idle, and a register write takes precedence.
   assign req_ready = (state_ff == FSM_IDLE) && !csr_write_enable;

   // State register; reset starts the clearing pass over the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (stat.count_last) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (csr_write_enable || req_valid) state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (stat.count_last) state_in = FSM_DRAIN;
         end
         FSM_DRAIN: begin
            state_in = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            state_in = stat.op_is_rescan ? FSM_IDLE : FSM_RESPOND;
         end
         FSM_RESPOND: begin
            if (stat.rsp_free) state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         FSM_CLEAR: begin
            cmd.clear_step   = 1'b1;
            cmd.commit_clear = stat.count_last;
         end
         FSM_IDLE: begin
            cmd.take_rescan = csr_write_enable;
            cmd.take_req    = req_valid && req_ready;
         end
         FSM_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         FSM_DRAIN: begin
            cmd = '0;
         end
         FSM_COMMIT: begin
            cmd.commit = 1'b1;
         end
         FSM_RESPOND: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/obpt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the order best-price tracker: order table memory, scan
// accumulators, best-price registers, mode register and result register.
// Depends on obpt_pkg and obpt_ram.
module obpt_datapath
   import obpt_pkg::*;
#(
   parameter int ENTRIES = OBPT_ENTRIES
) (
   input  logic          clock,
   input  logic          reset,
   input  obpt_cmd_type  cmd,
   output obpt_stat_type stat,
   input  obpt_req_type  req_data,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output obpt_rsp_type  rsp_data
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ENTRY_W = $bits(obpt_entry_type);

   // Mode register.
   logic mode_ff, mode_in;

   // Slot counter and visit pipeline behind the memory read.
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             vis_valid_ff;
   logic [IDX_W-1:0] vis_idx_ff;

   // Request and scan accumulators.
   obpt_req_type       req_ff, req_in;
   obpt_op_type        op_ff, op_in;
   logic               dup_ff, dup_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_slot_ff, free_slot_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_slot_ff, hit_slot_in;
   logic [PRICE_W-1:0] hit_price_ff, hit_price_in;
   logic [PRICE_W-1:0] cand_value_ff, cand_value_in;
   logic               cand_present_ff, cand_present_in;
   logic [KEY_W-1:0]   cand_key_ff, cand_key_in;

   // Best price and the outcome of the last commit.
   logic [PRICE_W-1:0] best_value_ff, best_value_in;
   logic               best_present_ff, best_present_in;
   logic [KEY_W-1:0]   best_key_ff, best_key_in;
   obpt_status_type    status_ff, status_in;
   logic [PRICE_W-1:0] removed_ff, removed_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   obpt_rsp_type rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   obpt_entry_type   ram_wr_entry;
   logic [ENTRY_W-1:0] ram_rd_data;
   obpt_entry_type   rd_entry;

   logic match;
   logic first_hit;
   logic count_last;

   obpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (cmd.scan_step),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry   = obpt_entry_type'(ram_rd_data);
   assign count_last = (cnt_ff == IDX_W'(ENTRIES - 1));

   assign stat.count_last   = count_last;
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   assign stat.op_is_rescan = (op_ff == OP_RESCAN);

   // The mode register is written from the configuration port at once.
   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   // Slot counter: restarts with each pass and wraps after the last slot.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.take_req || cmd.take_rescan) begin
         cnt_in = '0;
      end else if (cmd.scan_step || cmd.clear_step) begin
         cnt_in = count_last ? '0 : IDX_W'(cnt_ff + 1'b1);
      end
   end

   // Key match on the visited entry; a remove takes only the first match.
   assign match     = rd_entry.used && (rd_entry.key == req_ff.order_key);
   assign first_hit = match && !hit_ff && (op_ff == OP_REMOVE);

   // Scan accumulators: duplicate and free slot for an insert, the first
   // match for a remove, and the best over the entries that stay in use.
   always_comb begin
      req_in          = req_ff;
      op_in           = op_ff;
      dup_in          = dup_ff;
      free_found_in   = free_found_ff;
      free_slot_in    = free_slot_ff;
      hit_in          = hit_ff;
      hit_slot_in     = hit_slot_ff;
      hit_price_in    = hit_price_ff;
      cand_value_in   = cand_value_ff;
      cand_present_in = cand_present_ff;
      cand_key_in     = cand_key_ff;
      if (cmd.take_req || cmd.take_rescan) begin
         if (cmd.take_rescan) begin
            op_in = OP_RESCAN;
         end else begin
            req_in = req_data;
            op_in  = (req_data.cmd == CMD_REMOVE) ? OP_REMOVE : OP_INSERT;
         end
         dup_in          = 1'b0;
         free_found_in   = 1'b0;
         free_slot_in    = '0;
         hit_in          = 1'b0;
         hit_slot_in     = '0;
         hit_price_in    = '0;
         cand_value_in   = obpt_empty(mode_in);
         cand_present_in = 1'b0;
         cand_key_in     = '0;
      end else if (vis_valid_ff) begin
         if (match) begin
            dup_in = 1'b1;
         end
         if (!rd_entry.used && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = vis_idx_ff;
         end
         if (first_hit) begin
            hit_in       = 1'b1;
            hit_slot_in  = vis_idx_ff;
            hit_price_in = rd_entry.price;
         end
         if (rd_entry.used && !first_hit &&
             obpt_better(mode_ff, rd_entry.price, cand_value_ff)) begin
            cand_value_in   = rd_entry.price;
            cand_present_in = 1'b1;
            cand_key_in     = rd_entry.key;
         end
      end
   end

   // Commit and clearing pass: table write, best update and result status.
   always_comb begin
      best_value_in   = best_value_ff;
      best_present_in = best_present_ff;
      best_key_in     = best_key_ff;
      status_in       = status_ff;
      removed_in      = removed_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = cnt_ff;
      ram_wr_entry    = '0;
      if (cmd.clear_step) begin
         ram_wr_en = 1'b1;
      end
      if (cmd.commit_clear) begin
         best_value_in   = obpt_empty(mode_in);
         best_present_in = 1'b0;
         best_key_in     = '0;
      end
      if (cmd.commit) begin
         removed_in = '0;
         status_in  = STAT_OK;
         unique case (op_ff)
            OP_INSERT: begin
               if (req_ff.check_duplicate && dup_ff) begin
                  status_in = STAT_DUP;
               end else if (!free_found_ff) begin
                  status_in = STAT_FULL;
               end else begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = free_slot_ff;
                  ram_wr_entry.used  = 1'b1;
                  ram_wr_entry.price = req_ff.order_price;
                  ram_wr_entry.key   = req_ff.order_key;
                  if (obpt_better(mode_ff, req_ff.order_price, best_value_ff)) begin
                     best_value_in   = req_ff.order_price;
                     best_present_in = 1'b1;
                     best_key_in     = req_ff.order_key;
                  end
               end
            end
            OP_REMOVE: begin
               if (hit_ff) begin
                  ram_wr_en       = 1'b1;
                  ram_wr_addr     = hit_slot_ff;
                  removed_in      = hit_price_ff;
                  best_value_in   = cand_value_ff;
                  best_present_in = cand_present_ff;
                  best_key_in     = cand_key_ff;
               end else begin
                  status_in = STAT_MISS;
               end
            end
            OP_RESCAN: begin
               best_value_in   = cand_value_ff;
               best_present_in = cand_present_ff;
               best_key_in     = cand_key_ff;
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   // Result register: loaded once per request, held until the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = status_ff;
         rsp_data_in.removed_price = removed_ff;
         rsp_data_in.best_valid    = best_present_ff;
         rsp_data_in.best_price    = best_value_ff;
         rsp_data_in.best_key      = best_key_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         cnt_ff          <= '0;
         vis_valid_ff    <= 1'b0;
         op_ff           <= OP_INSERT;
         best_value_ff   <= '0;
         best_present_ff <= 1'b0;
         best_key_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         cnt_ff          <= cnt_in;
         vis_valid_ff    <= cmd.scan_step;
         op_ff           <= op_in;
         best_value_ff   <= best_value_in;
         best_present_ff <= best_present_in;
         best_key_ff     <= best_key_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      vis_idx_ff      <= cnt_ff;
      req_ff          <= req_in;
      dup_ff          <= dup_in;
      free_found_ff   <= free_found_in;
      free_slot_ff    <= free_slot_in;
      hit_ff          <= hit_in;
      hit_slot_ff     <= hit_slot_in;
      hit_price_ff    <= hit_price_in;
      cand_value_ff   <= cand_value_in;
      cand_present_ff <= cand_present_in;
      cand_key_ff     <= cand_key_in;
      status_ff       <= status_in;
      removed_ff      <= removed_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/order_best_price_tracker_unit.sv =====
`timescale 1ns / 1ps
// Order best-price tracker. It keeps a table of ENTRIES open orders (key and
// price) in one memory and tracks the highest (buy side) or lowest (sell
// side) price as the mode register selects. Each request reads every slot of
// the table once through the memory's single read port, and its result waits
// in the result register until it is taken; requests are handled one at a
// time. A mode write rescans the table. After reset a clearing pass over
// every slot runs with req_ready low; mode writes are taken meanwhile.
// Depends on obpt_pkg, obpt_ctrl, obpt_datapath and obpt_ram.
module order_best_price_tracker_unit
   import obpt_pkg::*;
#(
   parameter int ENTRIES = OBPT_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  obpt_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output obpt_rsp_type rsp_data,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   obpt_cmd_type  cmd;
   obpt_stat_type stat;

   // Sequencer.
   obpt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .csr_write_enable (csr_write_enable),
      .stat             (stat),
      .cmd              (cmd)
   );

   // Table, scan and result datapath.
   obpt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for order_best_price_tracker_unit. A scoreboard class
// keeps its own copy of the order table and best price and checks every response.
// Depends on obpt_pkg and the tracker RTL.
module tb;
   import obpt_pkg::*;

   localparam int TABLE_DEPTH = OBPT_ENTRIES;
   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int CHUNK_ITEMS = 117;
   localparam int CHUNKS      = 12;
   localparam int KEY_POOL    = 40;
   localparam logic [KEY_W-1:0]   KEY_BASE  = 64'h4F52_4430_3030_3030;
   localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
   localparam logic [KEY_W-1:0]   BUY1  = 64'h4255_5930_3030_3031;
   localparam logic [KEY_W-1:0]   BUY2  = 64'h4255_5930_3030_3032;
   localparam logic [KEY_W-1:0]   BUY3  = 64'h4255_5930_3030_3033;
   localparam logic [KEY_W-1:0]   BUY4  = 64'h4255_5930_3030_3034;
   localparam logic [KEY_W-1:0]   SELL1 = 64'h5345_4C4C_3030_3031;
   localparam logic [KEY_W-1:0]   SELL2 = 64'h5345_4C4C_3030_3032;
   localparam logic [KEY_W-1:0]   SELL3 = 64'h5345_4C4C_3030_3033;
   localparam logic [KEY_W-1:0]   SELL9 = 64'h5345_4C4C_3030_3039;

   // Order table shadow, best-price tracking and the queue of expected responses.
   class order_book_scoreboard;
      bit [KEY_W-1:0]   slot_key[TABLE_DEPTH];
      bit [PRICE_W-1:0] slot_price[TABLE_DEPTH];
      bit               slot_taken[TABLE_DEPTH];
      bit [PRICE_W-1:0] top_price;
      int               top_slot;
      bit               top_held;
      bit               lowest_mode;
      obpt_rsp_type     expected_rsp_q[$];
      int               status_seen[4];
      int               failures;

      function bit beats(bit [PRICE_W-1:0] cand, bit [PRICE_W-1:0] cur);
         return lowest_mode ? (cand < cur) : (cand > cur);
      endfunction

      // Full pass over the table; the lowest slot keeps a tie.
      function void rescan_top();
         top_price = lowest_mode ? EMPTY_LOW_PRICE : '0;
         top_slot  = 0;
         top_held  = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_taken[i] && beats(slot_price[i], top_price)) begin
               top_price = slot_price[i];
               top_slot  = i;
               top_held  = 1'b1;
            end
         end
      endfunction

      function void set_mode(bit lowest);
         lowest_mode = lowest;
         rescan_top();
      endfunction

      function obpt_rsp_type predict_book_response(obpt_req_type r);
         obpt_rsp_type rsp;
         bit           dup;
         int           free_slot;
         int           hit_slot;
         rsp        = '0;
         rsp.status = STAT_OK;
         dup        = 1'b0;
         free_slot  = -1;
         hit_slot   = -1;
         if (r.cmd == CMD_INSERT) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_taken[i]) begin
                  if (slot_key[i] == r.order_key) dup = 1'b1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            // The duplicate check wins over a full table.
            if (r.check_duplicate && dup) begin
               rsp.status = STAT_DUP;
            end else if (free_slot < 0) begin
               rsp.status = STAT_FULL;
            end else begin
               slot_key[free_slot]   = r.order_key;
               slot_price[free_slot] = r.order_price;
               slot_taken[free_slot] = 1'b1;
               if (beats(r.order_price, top_price)) begin
                  top_price = r.order_price;
                  top_slot  = free_slot;
                  top_held  = 1'b1;
               end
            end
         end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (hit_slot < 0 && slot_taken[i] && slot_key[i] == r.order_key) hit_slot = i;
            end
            if (hit_slot < 0) begin
               rsp.status = STAT_MISS;
            end else begin
               rsp.removed_price    = slot_price[hit_slot];
               slot_taken[hit_slot] = 1'b0;
               rescan_top();
            end
         end
         rsp.best_valid = top_held;
         rsp.best_price = top_price;
         rsp.best_key   = top_held ? slot_key[top_slot] : '0;
         return rsp;
      endfunction

      function void note_request(obpt_req_type r);
         expected_rsp_q.push_back(predict_book_response(r));
      endfunction

      function void compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(obpt_rsp_type got);
         obpt_rsp_type want;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response %h arrived with none expected", $time, got);
            failures++;
            return;
         end
         want = expected_rsp_q.pop_front();
         status_seen[want.status]++;
         compare_field("status", KEY_W'(want.status), KEY_W'(got.status));
         compare_field("removed_price", KEY_W'(want.removed_price),
                       KEY_W'(got.removed_price));
         compare_field("best_valid", KEY_W'(want.best_valid), KEY_W'(got.best_valid));
         compare_field("best_price", KEY_W'(want.best_price), KEY_W'(got.best_price));
         compare_field("best_key", want.best_key, got.best_key);
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      // Key of a randomly chosen stored order, so removes mostly hit.
      function bit [KEY_W-1:0] stored_key_sample(output bit found);
         int taken_q[$];
         foreach (slot_taken[i]) begin
            if (slot_taken[i]) taken_q.push_back(i);
         end
         found = (taken_q.size() != 0);
         if (!found) return '0;
         return slot_key[taken_q[$urandom_range(taken_q.size() - 1)]];
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   obpt_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   obpt_rsp_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data = 1'b0;

   order_book_scoreboard book = new();
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_rsp_request = 1'b0;
   int idle_cycles = 0;
   int requests_sent = 0;
   int mode_writes = 0;

   order_best_price_tracker_unit #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic obpt_req_type make_req(logic cmd, logic [KEY_W-1:0] key,
                                             logic [PRICE_W-1:0] price, logic check);
      obpt_req_type r;
      r.cmd             = cmd;
      r.order_key       = key;
      r.order_price     = price;
      r.check_duplicate = check;
      return r;
   endfunction

   // Prices lean on the empty values and a tight cluster so ties are common.
   function automatic logic [PRICE_W-1:0] random_price();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      case ($urandom_range(15))
         0, 1: return '0;
         2, 3: return EMPTY_LOW_PRICE;
         4: return wide[PRICE_W-1:0];
         5, 6, 7, 8: return 37'd5000000 + PRICE_W'($urandom_range(3));
         default: return PRICE_W'(wide % 64'(EMPTY_LOW_PRICE + 37'd1));
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pool_key();
      return KEY_BASE + KEY_W'($urandom_range(KEY_POOL - 1));
   endfunction

   function automatic obpt_req_type random_request(int insert_pct);
      logic [KEY_W-1:0] key;
      bit               found;
      int               pick;
      pick = $urandom_range(7);
      if ($urandom_range(99) < insert_pct) begin
         key = (pick == 7) ? {$urandom(), $urandom()} : pool_key();
         return make_req(CMD_INSERT, key, random_price(), 1'($urandom_range(1)));
      end
      key = book.stored_key_sample(found);
      if (!found || pick == 6) key = pool_key();
      if (pick == 7) key = {$urandom(), $urandom()};
      return make_req(CMD_REMOVE, key, random_price(), 1'($urandom_range(1)));
   endfunction

   // Offer one request, with a random gap first, and hold it until the transfer.
   task automatic push_request(input obpt_req_type r);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      book.note_request(r);
      requests_sent++;
      @(negedge clock);
   endtask

   // Change the mode only once every response has come back.
   task automatic write_mode(input logic lowest);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= lowest;
      @(posedge clock);
      book.set_mode(lowest);
      mode_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Response side: random stalls plus one long hold-off when asked.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_left        = HOLD_CYCLES;
            hold_rsp_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) book.check_response(rsp_data);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int insert_pct;
      insert_pct = 50;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct  = 13;
      rsp_stall_pct = 63;
      write_mode(1'b0);

      // Highest mode: empty table, zero price, out-of-range price, duplicates, ties.
      push_request(make_req(CMD_REMOVE, BUY1, PRICE_TOP, 1'b1));
      push_request(make_req(CMD_INSERT, BUY1, '0, 1'b1));
      push_request(make_req(CMD_INSERT, BUY2, PRICE_TOP, 1'b0));
      push_request(make_req(CMD_INSERT, BUY3, 37'd5000000, 1'b1));
      push_request(make_req(CMD_INSERT, BUY3, 37'd7000000, 1'b1));
      push_request(make_req(CMD_INSERT, BUY3, 37'd5000000, 1'b0));
      push_request(make_req(CMD_INSERT, BUY4, 37'd5000000, 1'b0));
      push_request(make_req(CMD_REMOVE, BUY2, '0, 1'b0));
      push_request(make_req(CMD_REMOVE, BUY3, '0, 1'b0));
      push_request(make_req(CMD_INSERT, '1, EMPTY_LOW_PRICE, 1'b1));
      push_request(make_req(CMD_INSERT, '0, 37'd1, 1'b0));
      push_request(make_req(CMD_REMOVE, '0, PRICE_TOP, 1'b1));

      // Lowest mode over the same table: the stored zero price becomes the best.
      write_mode(1'b1);
      push_request(make_req(CMD_INSERT, SELL1, EMPTY_LOW_PRICE, 1'b0));
      push_request(make_req(CMD_INSERT, SELL2, PRICE_TOP, 1'b1));
      push_request(make_req(CMD_REMOVE, BUY1, '0, 1'b0));
      push_request(make_req(CMD_INSERT, SELL3, 37'd1, 1'b1));
      push_request(make_req(CMD_REMOVE, SELL9, 37'd1, 1'b0));
      push_request(make_req(CMD_REMOVE, SELL3, '0, 1'b1));

      // Random chunks alternate the mode and swing between filling and draining.
      for (int c = 0; c < CHUNKS; c++) begin
         write_mode(c[0]);
         case (c / 4)
            0: begin
               send_gap_pct  = 13;
               rsp_stall_pct = 63;
            end
            1: begin
               send_gap_pct  = 63;
               rsp_stall_pct = 13;
            end
            default: begin
               send_gap_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         case (c % 3)
            0: insert_pct = 85;
            1: insert_pct = 30;
            default: insert_pct = 55;
         endcase
         if (c == 1 || c == 9) hold_rsp_request = 1'b1;
         for (int n = 0; n < CHUNK_ITEMS; n++) push_request(random_request(insert_pct));
      end
      req_valid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      $display("tb: %0d requests over %0d mode writes; ok %0d, duplicate %0d,",
               requests_sent, mode_writes, book.status_seen[STAT_OK],
               book.status_seen[STAT_DUP]);
      $display("tb: table full %0d, key not found %0d, mismatches %0d",
               book.status_seen[STAT_FULL], book.status_seen[STAT_MISS], book.failures);
      if (book.failures == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
